// ----- rtl/iwrd_pkg.sv -----
`default_nettype none
package iwrd_pkg;

  localparam int unsigned WORKERS    = 16;
  localparam int unsigned WAIT_DEPTH = 16;

  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned CLIENT_W = 16;
  localparam int unsigned WORKER_W = 4;
  localparam int unsigned OUTC_W   = 3;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned LIMIT_W  = 5;

  localparam int unsigned IDLE_AW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int unsigned IDLE_CW = $clog2(WORKERS + 1);
  localparam int unsigned WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned WAIT_CW = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned CMP_W   = (LIMIT_W > WAIT_CW) ? LIMIT_W : WAIT_CW;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(4);

  typedef enum logic [FUNC_W-1:0] {
    FN_CLIENT = 1'b0,
    FN_WORKER = 1'b1
  } func_e;

  typedef enum logic [OUTC_W-1:0] {
    OC_DIRECT  = 3'd0,
    OC_QUEUED  = 3'd1,
    OC_REFUSED = 3'd2,
    OC_GIVEN   = 3'd3,
    OC_IDLES   = 3'd4
  } outcome_e;

  typedef struct packed {
    logic load;
    logic cfg_we;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/iwrd_if.sv -----
`default_nettype none
interface iwrd_req_if;
  import iwrd_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CLIENT_W-1:0] client_id;
  logic [WORKER_W-1:0] worker_id;

  modport source (output valid, func, client_id, worker_id, input ready);
  modport sink   (input valid, func, client_id, worker_id, output ready);
endinterface

interface iwrd_rsp_if;
  import iwrd_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUTC_W-1:0]   outcome;
  logic [WORKER_W-1:0] matched_worker;
  logic [CLIENT_W-1:0] matched_client;
  logic [CNT_W-1:0]    served_at_once;
  logic [CNT_W-1:0]    served_after_wait;
  logic [CNT_W-1:0]    turned_away;

  modport source (output valid, outcome, matched_worker, matched_client,
                  served_at_once, served_after_wait, turned_away, input ready);
  modport sink   (input valid, outcome, matched_worker, matched_client,
                  served_at_once, served_after_wait, turned_away, output ready);
endinterface

interface iwrd_cfg_if;
  import iwrd_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] wait_limit;

  modport source (output valid, wait_limit, input ready);
  modport sink   (input valid, wait_limit, output ready);
endinterface
`default_nettype wire

// ----- rtl/iwrd_ctrl.sv -----
`default_nettype none
module iwrd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  output iwrd_pkg::cmd_t     cmd_o
);
  import iwrd_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // output register may be refilled in the cycle it drains
  assign req_ready_o   = (state_q == ST_EMPTY) || rsp_ready_i;
  assign rsp_valid_o   = (state_q == ST_FULL);
  assign cfg_ready_o   = 1'b1;
  assign cmd_o.load    = req_valid_i && req_ready_o;
  assign cmd_o.cfg_we  = cfg_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EMPTY: begin
        if (cmd_o.load) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (rsp_ready_i && !cmd_o.load) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/iwrd_dp.sv -----
`default_nettype none
module iwrd_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire iwrd_pkg::cmd_t                   cmd_i,
  input  wire logic [iwrd_pkg::FUNC_W-1:0]      func_i,
  input  wire logic [iwrd_pkg::CLIENT_W-1:0]    client_id_i,
  input  wire logic [iwrd_pkg::WORKER_W-1:0]    worker_id_i,
  input  wire logic [iwrd_pkg::LIMIT_W-1:0]     wait_limit_i,
  output logic [iwrd_pkg::OUTC_W-1:0]           outcome_o,
  output logic [iwrd_pkg::WORKER_W-1:0]         matched_worker_o,
  output logic [iwrd_pkg::CLIENT_W-1:0]         matched_client_o,
  output logic [iwrd_pkg::CNT_W-1:0]            served_at_once_o,
  output logic [iwrd_pkg::CNT_W-1:0]            served_after_wait_o,
  output logic [iwrd_pkg::CNT_W-1:0]            turned_away_o
);
  import iwrd_pkg::*;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  logic [WORKER_W-1:0] idle_mem_q [WORKERS];
  logic [CLIENT_W-1:0] wait_mem_q [WAIT_DEPTH];

  logic [IDLE_AW-1:0] idle_head_q, idle_tail_q;
  logic [IDLE_CW-1:0] idle_cnt_q;
  logic [WAIT_AW-1:0] wait_head_q, wait_tail_q;
  logic [WAIT_CW-1:0] wait_cnt_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [CNT_W-1:0]   direct_q, queued_q, refused_q;

  outcome_e            outcome_q, outcome_d;
  logic [WORKER_W-1:0] mworker_q, mworker_d;
  logic [CLIENT_W-1:0] mclient_q, mclient_d;

  logic idle_pop, idle_push, wait_pop, wait_push;
  logic [CMP_W-1:0] lim_ext, lim_eff;
  logic wait_room;

  assign lim_ext   = CMP_W'(limit_q);
  assign lim_eff   = (lim_ext < CMP_W'(WAIT_DEPTH)) ? lim_ext : CMP_W'(WAIT_DEPTH);
  assign wait_room = CMP_W'(wait_cnt_q) < lim_eff;

  always_comb begin
    outcome_d = OC_IDLES;
    mworker_d = '0;
    mclient_d = '0;
    idle_pop  = 1'b0;
    idle_push = 1'b0;
    wait_pop  = 1'b0;
    wait_push = 1'b0;
    if (func_i == FN_CLIENT) begin
      if (idle_cnt_q != '0) begin
        outcome_d = OC_DIRECT;
        mclient_d = client_id_i;
        idle_pop  = 1'b1;
      end else if (wait_room) begin
        outcome_d = OC_QUEUED;
        wait_push = 1'b1;
      end else begin
        outcome_d = OC_REFUSED;
      end
    end else begin
      if (wait_cnt_q != '0) begin
        outcome_d = OC_GIVEN;
        mworker_d = worker_id_i;
        wait_pop  = 1'b1;
      end else begin
        outcome_d = OC_IDLES;
        idle_push = (idle_cnt_q != IDLE_CW'(WORKERS));
      end
    end
  end

  // popped ids are read straight into the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && idle_push) idle_mem_q[idle_tail_q] <= worker_id_i;
    if (cmd_i.load && wait_push) wait_mem_q[wait_tail_q] <= client_id_i;
    if (cmd_i.load) begin
      outcome_q <= outcome_d;
      mworker_q <= idle_pop ? idle_mem_q[idle_head_q] : mworker_d;
      mclient_q <= wait_pop ? wait_mem_q[wait_head_q] : mclient_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_head_q <= '0;
      idle_tail_q <= '0;
      idle_cnt_q  <= '0;
      wait_head_q <= '0;
      wait_tail_q <= '0;
      wait_cnt_q  <= '0;
      limit_q     <= LIMIT_RST;
      direct_q    <= '0;
      queued_q    <= '0;
      refused_q   <= '0;
    end else begin
      if (cmd_i.cfg_we) limit_q <= wait_limit_i;
      if (cmd_i.load) begin
        if (idle_pop) begin
          idle_head_q <= (idle_head_q == IDLE_AW'(WORKERS - 1)) ? '0 : idle_head_q + 1'b1;
          idle_cnt_q  <= idle_cnt_q - 1'b1;
          direct_q    <= sat_inc(direct_q);
        end
        if (idle_push) begin
          idle_tail_q <= (idle_tail_q == IDLE_AW'(WORKERS - 1)) ? '0 : idle_tail_q + 1'b1;
          idle_cnt_q  <= idle_cnt_q + 1'b1;
        end
        if (wait_pop) begin
          wait_head_q <= (wait_head_q == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : wait_head_q + 1'b1;
          wait_cnt_q  <= wait_cnt_q - 1'b1;
        end
        if (wait_push) begin
          wait_tail_q <= (wait_tail_q == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : wait_tail_q + 1'b1;
          wait_cnt_q  <= wait_cnt_q + 1'b1;
          queued_q    <= sat_inc(queued_q);
        end
        if (outcome_d == OC_REFUSED) refused_q <= sat_inc(refused_q);
      end
    end
  end

  // totals only move on load, which retires any held beat in the same edge
  assign outcome_o           = outcome_q;
  assign matched_worker_o    = mworker_q;
  assign matched_client_o    = mclient_q;
  assign served_at_once_o    = direct_q;
  assign served_after_wait_o = queued_q;
  assign turned_away_o       = refused_q;

endmodule
`default_nettype wire

// ----- rtl/idle_worker_request_dispatcher_top.sv -----
// channel | dir | handshake      | payload
// req_i   | in  | valid / ready  | func, client_id, worker_id
// rsp_o   | out | valid / ready  | outcome, matched_worker, matched_client, 3 totals
// cfg_i   | in  | valid / ready  | wait_limit
//
// One request per cycle unless rsp_o stalls; result valid the cycle after acceptance.
// The single output register sets the rate: req_i.ready is high whenever that
// register is empty or being drained in the same cycle.
// rsp_o stalls back-pressure req_i directly; no beat is dropped.
// Reset is asynchronous, active low; wait_limit resets to 4, FIFOs and totals empty.
`default_nettype none
module idle_worker_request_dispatcher_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  iwrd_req_if.sink    req_i,
  iwrd_rsp_if.source  rsp_o,
  iwrd_cfg_if.sink    cfg_i
);
  import iwrd_pkg::*;

  cmd_t cmd;

  iwrd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cmd_o       (cmd)
  );

  iwrd_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .func_i              (req_i.func),
    .client_id_i         (req_i.client_id),
    .worker_id_i         (req_i.worker_id),
    .wait_limit_i        (cfg_i.wait_limit),
    .outcome_o           (rsp_o.outcome),
    .matched_worker_o    (rsp_o.matched_worker),
    .matched_client_o    (rsp_o.matched_client),
    .served_at_once_o    (rsp_o.served_at_once),
    .served_after_wait_o (rsp_o.served_after_wait),
    .turned_away_o       (rsp_o.turned_away)
  );

endmodule
`default_nettype wire

// ----- rtl/iwrd_chk.sv -----
`default_nettype none
module iwrd_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            req_valid_i,
  input wire logic                            req_ready_i,
  input wire logic                            rsp_valid_i,
  input wire logic                            rsp_ready_i,
  input wire logic [iwrd_pkg::OUTC_W-1:0]     outcome_i,
  input wire logic [iwrd_pkg::WORKER_W-1:0]   matched_worker_i,
  input wire logic [iwrd_pkg::CLIENT_W-1:0]   matched_client_i,
  input wire logic [iwrd_pkg::CNT_W-1:0]      served_at_once_i
);
  import iwrd_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result beat dropped while stalled");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("no result beat after accepted request");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("request taken while result stalled");

  a_unpaired_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (outcome_i == OC_QUEUED || outcome_i == OC_REFUSED ||
                    outcome_i == OC_IDLES)
    |-> matched_worker_i == '0 && matched_client_i == '0)
    else $error("unpaired outcome carries match ids");

  a_direct_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> served_at_once_i >= $past(served_at_once_i))
    else $error("served_at_once decreased");

endmodule

bind idle_worker_request_dispatcher_top iwrd_chk u_iwrd_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .outcome_i        (rsp_o.outcome),
  .matched_worker_i (rsp_o.matched_worker),
  .matched_client_i (rsp_o.matched_client),
  .served_at_once_i (rsp_o.served_at_once)
);
`default_nettype wire

// ----- sim/idle_worker_request_dispatcher_checker.sv -----
`timescale 1ns / 100ps
module iwrd_dispatch_checker
  import iwrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  iwrd_req_if         req_i,
  iwrd_rsp_if         rsp_i,
  iwrd_cfg_if         cfg_i,
  output int unsigned pending_o = 0,
  output int unsigned fail_cnt_o = 0,
  output int unsigned outcome_cnt_o [5]
);

  typedef struct packed {
    outcome_e            outcome;
    logic [WORKER_W-1:0] worker;
    logic [CLIENT_W-1:0] client;
    logic [CNT_W-1:0]    direct_cnt;
    logic [CNT_W-1:0]    queued_cnt;
    logic [CNT_W-1:0]    refused_cnt;
  } dispatch_t;

  logic [WORKER_W-1:0] idle_ids [WORKERS];
  int unsigned         idle_rd;
  int unsigned         idle_num;
  logic [CLIENT_W-1:0] wait_ids [WAIT_DEPTH];
  int unsigned         wait_rd;
  int unsigned         wait_num;
  logic [CNT_W-1:0]    direct_cnt;
  logic [CNT_W-1:0]    queued_cnt;
  logic [CNT_W-1:0]    refused_cnt;
  logic [LIMIT_W-1:0]  limit_q;
  dispatch_t           expected_q [$];

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic dispatch(input func_e fn, input logic [CLIENT_W-1:0] client,
                          input logic [WORKER_W-1:0] worker, output dispatch_t r);
    int unsigned cap;
    r   = '0;
    cap = (limit_q < WAIT_DEPTH) ? limit_q : WAIT_DEPTH;
    if (fn == FN_CLIENT) begin
      if (idle_num > 0) begin
        r.outcome  = OC_DIRECT;
        r.worker   = idle_ids[idle_rd];
        r.client   = client;
        idle_rd    = (idle_rd + 1) % WORKERS;
        idle_num--;
        direct_cnt = bump(direct_cnt);
      end else if (wait_num < cap) begin
        r.outcome = OC_QUEUED;
        wait_ids[(wait_rd + wait_num) % WAIT_DEPTH] = client;
        wait_num++;
        queued_cnt = bump(queued_cnt);
      end else begin
        r.outcome   = OC_REFUSED;
        refused_cnt = bump(refused_cnt);
      end
    end else begin
      if (wait_num > 0) begin
        r.outcome = OC_GIVEN;
        r.client  = wait_ids[wait_rd];
        r.worker  = worker;
        wait_rd   = (wait_rd + 1) % WAIT_DEPTH;
        wait_num--;
      end else begin
        r.outcome = OC_IDLES;
        // a full idle list drops the worker
        if (idle_num < WORKERS) begin
          idle_ids[(idle_rd + idle_num) % WORKERS] = worker;
          idle_num++;
        end
      end
    end
    r.direct_cnt  = direct_cnt;
    r.queued_cnt  = queued_cnt;
    r.refused_cnt = refused_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_t want;
    dispatch_t seen;
    if (!rst_ni) begin
      idle_rd     = 0;
      idle_num    = 0;
      wait_rd     = 0;
      wait_num    = 0;
      direct_cnt  = '0;
      queued_cnt  = '0;
      refused_cnt = '0;
      limit_q     = LIMIT_RST;
      expected_q.delete();
      pending_o   = 0;
      fail_cnt_o  = 0;
      for (int i = 0; i < 5; i++) outcome_cnt_o[i] = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) limit_q = cfg_i.wait_limit;
      if (rsp_i.valid && rsp_i.ready) begin
        seen.outcome     = outcome_e'(rsp_i.outcome);
        seen.worker      = rsp_i.matched_worker;
        seen.client      = rsp_i.matched_client;
        seen.direct_cnt  = rsp_i.served_at_once;
        seen.queued_cnt  = rsp_i.served_after_wait;
        seen.refused_cnt = rsp_i.turned_away;
        if (expected_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: result beat with no request outstanding, outcome %0d",
                     $time, rsp_i.outcome);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display({"%0t: mismatch: expected outcome %0d worker %0d client %h",
                        " totals %0d/%0d/%0d, got outcome %0d worker %0d client %h",
                        " totals %0d/%0d/%0d"}, $time,
                       want.outcome, want.worker, want.client, want.direct_cnt,
                       want.queued_cnt, want.refused_cnt,
                       rsp_i.outcome, seen.worker, seen.client, seen.direct_cnt,
                       seen.queued_cnt, seen.refused_cnt);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        dispatch(func_e'(req_i.func), req_i.client_id, req_i.worker_id, want);
        expected_q.insert(expected_q.size(), want);
        outcome_cnt_o[want.outcome]++;
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- sim/idle_worker_request_dispatcher_top_test.sv -----
`timescale 1ns / 100ps
module idle_worker_request_dispatcher_top_test;
  import iwrd_pkg::*;

  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  localparam int unsigned PHASE_LIMIT [PHASES] = '{0, 16, 31, 3, 1, 16, 5, 0};
  localparam int unsigned CLIENT_PCT  [PHASES] = '{50, 70, 70, 40, 50, 30, 60, 50};

  logic        clk;
  logic        rst_n;
  bit          hold_rq = 1'b0;
  int unsigned pending;
  int unsigned fail_cnt;
  int unsigned outcome_cnt [5];
  int unsigned sent_cnt = 0;
  int unsigned limit_writes = 0;

  iwrd_req_if req ();
  iwrd_rsp_if rsp ();
  iwrd_cfg_if cfg ();

  idle_worker_request_dispatcher_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  iwrd_dispatch_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_i         (req),
    .rsp_i         (rsp),
    .cfg_i         (cfg),
    .pending_o     (pending),
    .fail_cnt_o    (fail_cnt),
    .outcome_cnt_o (outcome_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CLIENT_W-1:0] pick_client();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CLIENT_W'($urandom);
    endcase
  endfunction

  // called at a clock edge; returns at the edge where the beat is taken
  task automatic send_req(input func_e fn, input logic [CLIENT_W-1:0] client,
                          input logic [WORKER_W-1:0] worker);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.func      <= fn;
    req.client_id <= client;
    req.worker_id <= worker;
    do @(posedge clk); while (!req.ready);
    sent_cnt++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg.valid      <= 1'b1;
    cfg.wait_limit <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    limit_writes++;
  endtask

  initial begin : rsp_sink
    int unsigned g;
    rsp.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (hold_rq) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rq = 1'b0;
      end else begin
        g = pick_gap();
        if (g != 0) begin
          rsp.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: %0d cycles without a beat, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CLIENT_W-1:0] queued_ids [4];
    logic [LIMIT_W-1:0]  lim;
    queued_ids = '{16'h1234, 16'hABCD, 16'h5555, 16'hAAAA};

    rst_n          = 1'b0;
    req.valid      = 1'b0;
    req.func       = FN_CLIENT;
    req.client_id  = '0;
    req.worker_id  = '0;
    cfg.valid      = 1'b0;
    cfg.wait_limit = LIMIT_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit of 4: direct hits, queue to the limit, refusal, hand-offs
    send_req(FN_WORKER, 16'h0000, 4'h0);
    send_req(FN_WORKER, 16'hFFFF, 4'hF);
    send_req(FN_CLIENT, 16'h0000, 4'hF);
    send_req(FN_CLIENT, 16'hFFFF, 4'h0);
    for (int i = 0; i < 4; i++) send_req(FN_CLIENT, queued_ids[i], 4'(i));
    send_req(FN_CLIENT, 16'h0001, 4'h5);
    for (int i = 0; i < 4; i++) send_req(FN_WORKER, 16'hFFFF, 4'(i + 7));
    // fill the idle list, then one more (dropped, duplicate id)
    for (int i = 0; i <= 16; i++) send_req(FN_WORKER, CLIENT_W'($urandom), 4'(i));

    for (int p = 0; p < PHASES; p++) begin
      lim = (p == PHASES - 1) ? LIMIT_W'($urandom_range(0, 31)) : LIMIT_W'(PHASE_LIMIT[p]);
      write_limit(lim);
      if (p == 2) hold_rq = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < CLIENT_PCT[p])
          send_req(FN_CLIENT, pick_client(), WORKER_W'($urandom));
        else
          send_req(FN_WORKER, CLIENT_W'($urandom), WORKER_W'($urandom));
      end
    end

    drain();
    $display("sent %0d requests over %0d wait_limit writes, including one long sink stall",
             sent_cnt, limit_writes);
    $display("outcomes: direct %0d, queued %0d, refused %0d, given %0d, idled %0d",
             outcome_cnt[OC_DIRECT], outcome_cnt[OC_QUEUED], outcome_cnt[OC_REFUSED],
             outcome_cnt[OC_GIVEN], outcome_cnt[OC_IDLES]);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_cnt == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
